/* design/ssc_pkg.sv */
// Package for the supersampled shape coverage block.
// Holds defaults, register indexes, shape codes and the fixed edge tables.
`default_nettype none
package ssc_pkg;
    localparam int GRID_DEF       = 4;
    localparam int COORD_BITS_DEF = 10;

    localparam logic [1:0] MODE_CIRCLE = 2'd0;
    localparam logic [1:0] MODE_CONVEX = 2'd1;
    localparam logic [1:0] MODE_STAR   = 2'd2;

    localparam logic [1:0] REG_SHAPE_MODE = 2'd0;
    localparam logic [1:0] REG_CENTER_X   = 2'd1;
    localparam logic [1:0] REG_CENTER_Y   = 2'd2;
    localparam logic [1:0] REG_RADIUS     = 2'd3;

    localparam int CVX_N = 4;
    localparam int CVX_A  [CVX_N] = '{-3, 1, 8, 1};
    localparam int CVX_B  [CVX_N] = '{1, 2, -1, -7};
    localparam int CVX_X0 [CVX_N] = '{20, 200, 700, 200};
    localparam int CVX_Y0 [CVX_N] = '{20, 700, 400, 200};

    localparam int STAR_N = 5;
    localparam int STAR_A  [STAR_N] = '{-1, 8, -1, 1, 1};
    localparam int STAR_B  [STAR_N] = '{1, -1, -1, 2, -4};
    localparam int STAR_X0 [STAR_N] = '{20, 600, 600, 100, 100};
    localparam int STAR_Y0 [STAR_N] = '{20, 400, 200, 700, 200};
endpackage
`default_nettype wire

/* design/ssc_head.sv */
// Entry stage: registers the pixel and the per-row circle terms.
// Depends on ssc_pkg.
`default_nettype none
module ssc_head #(
    parameter int GRID       = ssc_pkg::GRID_DEF,
    parameter int COORD_BITS = ssc_pkg::COORD_BITS_DEF,
    parameter int EW         = 22,
    parameter int DW         = 45
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         valid_in,
    input  wire logic [COORD_BITS-1:0]        px_in,
    input  wire logic [COORD_BITS-1:0]        py_in,
    input  wire logic [COORD_BITS-1:0]        cy,
    input  wire logic [COORD_BITS-1:0]        radius,
    output logic                              valid_out,
    output logic [COORD_BITS-1:0]             px_out,
    output logic signed [EW-1:0]              sy_out   [GRID],
    output logic signed [DW-1:0]              dy2m_out [GRID]
);
    localparam int SCALE = 2 * GRID;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic signed [EW-1:0]  sy_reg   [GRID];
    logic signed [DW-1:0]  dy2m_reg [GRID];
    logic signed [EW-1:0]  sy_next  [GRID];
    logic signed [DW-1:0]  dy2m_next[GRID];
    logic signed [EW-1:0]  rr;
    logic signed [EW-1:0]  dy;

    always_comb begin
        rr = EW'(radius) * EW'(SCALE);
        dy = '0;
        for (int j = 0; j < GRID; j++) begin
            sy_next[j]   = EW'(py_in) * EW'(SCALE) + EW'(2 * j + 1);
            dy           = sy_next[j] - EW'(cy) * EW'(SCALE);
            dy2m_next[j] = DW'(dy) * DW'(dy) - DW'(rr) * DW'(rr);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= px_in;
            sy_reg   <= sy_next;
            dy2m_reg <= dy2m_next;
        end
    end

    assign valid_out = valid_reg;
    assign px_out    = px_reg;
    assign sy_out    = sy_reg;
    assign dy2m_out  = dy2m_reg;
endmodule
`default_nettype wire

/* design/ssc_cell.sv */
// One column cell: tests the samples of its column and adds the hits to the count.
// Depends on ssc_pkg.
`default_nettype none
module ssc_cell #(
    parameter int GRID       = ssc_pkg::GRID_DEF,
    parameter int COORD_BITS = ssc_pkg::COORD_BITS_DEF,
    parameter int EW         = 22,
    parameter int DW         = 45,
    parameter int CW         = 5,
    parameter int IDX        = 0
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic [1:0]                   mode,
    input  wire logic [COORD_BITS-1:0]        cx,
    input  wire logic                         valid_in,
    input  wire logic [COORD_BITS-1:0]        px_in,
    input  wire logic signed [EW-1:0]         sy_in   [GRID],
    input  wire logic signed [DW-1:0]         dy2m_in [GRID],
    input  wire logic [CW-1:0]                cnt_in,
    output logic                              valid_out,
    output logic [COORD_BITS-1:0]             px_out,
    output logic signed [EW-1:0]              sy_out   [GRID],
    output logic signed [DW-1:0]              dy2m_out [GRID],
    output logic [CW-1:0]                     cnt_out
);
    import ssc_pkg::*;
    localparam int SCALE = 2 * GRID;

    logic                  valid_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic signed [EW-1:0]  sy_reg   [GRID];
    logic signed [DW-1:0]  dy2m_reg [GRID];
    logic [CW-1:0]         cnt_reg;
    logic [CW-1:0]         cnt_next;
    logic signed [EW-1:0]  sx;
    logic signed [EW-1:0]  dx;
    logic signed [DW-1:0]  dx2;
    logic signed [EW-1:0]  e;
    logic                  hit;
    logic                  cvx_in;
    logic                  neg [STAR_N];
    logic                  star_in;

    always_comb begin
        sx       = EW'(px_in) * EW'(SCALE) + EW'(2 * IDX + 1);
        dx       = sx - EW'(cx) * EW'(SCALE);
        dx2      = DW'(dx) * DW'(dx);
        cnt_next = cnt_in;
        e        = '0;
        for (int j = 0; j < GRID; j++) begin
            cvx_in = 1'b1;
            for (int k = 0; k < CVX_N; k++) begin
                e = EW'(CVX_A[k]) * (sx - EW'(CVX_X0[k] * SCALE))
                  + EW'(CVX_B[k]) * (sy_in[j] - EW'(CVX_Y0[k] * SCALE));
                if (!e[EW-1]) begin
                    cvx_in = 1'b0;
                end
            end
            for (int k = 0; k < STAR_N; k++) begin
                e = EW'(STAR_A[k]) * (sx - EW'(STAR_X0[k] * SCALE))
                  + EW'(STAR_B[k]) * (sy_in[j] - EW'(STAR_Y0[k] * SCALE));
                neg[k] = e[EW-1];
            end
            star_in = 1'b0;
            for (int k = 0; k < STAR_N; k++) begin
                if (neg[k] && neg[(k + 1) % STAR_N] && neg[(k + 2) % STAR_N]) begin
                    star_in = 1'b1;
                end
            end
            case (mode)
                MODE_CIRCLE: hit = (dx2 + dy2m_in[j]) < 0;
                MODE_CONVEX: hit = cvx_in;
                MODE_STAR:   hit = star_in;
                default:     hit = 1'b0;
            endcase
            cnt_next = cnt_next + CW'(hit);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px_reg   <= px_in;
            sy_reg   <= sy_in;
            dy2m_reg <= dy2m_in;
            cnt_reg  <= cnt_next;
        end
    end

    assign valid_out = valid_reg;
    assign px_out    = px_reg;
    assign sy_out    = sy_reg;
    assign dy2m_out  = dy2m_reg;
    assign cnt_out   = cnt_reg;
endmodule
`default_nettype wire

/* design/supersampled_implicit_shape_coverage.sv */
// Supersampled shape coverage. Each pixel word is tested on a GRID x GRID grid of
// sub-samples against a circle, a convex polygon or a star; the result word carries the
// covered count and a blue/yellow shade. One pixel is accepted every cycle while the
// result side does not stall; the pipeline is one entry stage and one cell per sample
// column. A stall on the result side holds the whole pipeline. Registers sit on an APB
// port at byte addresses 0, 4, 8, 12. Depends on ssc_pkg, ssc_head and ssc_cell.
`default_nettype none
module supersampled_implicit_shape_coverage #(
    parameter int GRID       = ssc_pkg::GRID_DEF,
    parameter int COORD_BITS = ssc_pkg::COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [3:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [COORD_BITS-1:0] s_pixel_x,
    input  wire logic [COORD_BITS-1:0] s_pixel_y,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [4:0]                 m_covered_count,
    output logic [7:0]                 m_shade_red_green,
    output logic [7:0]                 m_shade_blue
);
    import ssc_pkg::*;

    localparam int SCALE = 2 * GRID;
    localparam int SW    = COORD_BITS + $clog2(SCALE) + 2;
    localparam int EW    = ((SW > 16) ? SW : 16) + 6;
    localparam int DW    = 2 * EW + 1;
    localparam int G2    = GRID * GRID;
    localparam int CW    = $clog2(G2 + 1);
    localparam int Den   = 2 * G2;

    function automatic logic [G2:0][7:0] rg_table();
        logic [G2:0][7:0] t;
        for (int c = 0; c <= G2; c++) begin
            t[c] = 8'((51 * (9 * G2 - 8 * c)) / Den);
        end
        return t;
    endfunction

    function automatic logic [G2:0][7:0] blue_table();
        logic [G2:0][7:0] t;
        for (int c = 0; c <= G2; c++) begin
            t[c] = 8'((51 * (G2 + 8 * c)) / Den);
        end
        return t;
    endfunction

    localparam logic [G2:0][7:0] RG_TAB   = rg_table();
    localparam logic [G2:0][7:0] BLUE_TAB = blue_table();

    logic [1:0]            mode_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [COORD_BITS-1:0] radius_reg;
    logic                  wr;
    logic                  en;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_CIRCLE;
            cx_reg     <= COORD_BITS'(400);
            cy_reg     <= COORD_BITS'(400);
            radius_reg <= COORD_BITS'(200);
        end else if (wr) begin
            case (paddr[3:2])
                REG_SHAPE_MODE: mode_reg   <= pwdata[1:0];
                REG_CENTER_X:   cx_reg     <= pwdata[COORD_BITS-1:0];
                REG_CENTER_Y:   cy_reg     <= pwdata[COORD_BITS-1:0];
                REG_RADIUS:     radius_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SHAPE_MODE: prdata = 32'(mode_reg);
            REG_CENTER_X:   prdata = 32'(cx_reg);
            REG_CENTER_Y:   prdata = 32'(cy_reg);
            REG_RADIUS:     prdata = 32'(radius_reg);
            default:        prdata = '0;
        endcase
    end

    logic                  valid_c [GRID+1];
    logic [COORD_BITS-1:0] px_c    [GRID+1];
    logic signed [EW-1:0]  sy_c    [GRID+1][GRID];
    logic signed [DW-1:0]  dy2m_c  [GRID+1][GRID];
    logic [CW-1:0]         cnt_c   [GRID+1];

    assign en       = !valid_c[GRID] || m_ready;
    assign s_ready  = en;
    assign cnt_c[0] = '0;

    ssc_head #(
        .GRID(GRID), .COORD_BITS(COORD_BITS), .EW(EW), .DW(DW)
    ) u_head (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .valid_in(s_valid), .px_in(s_pixel_x), .py_in(s_pixel_y),
        .cy(cy_reg), .radius(radius_reg),
        .valid_out(valid_c[0]), .px_out(px_c[0]),
        .sy_out(sy_c[0]), .dy2m_out(dy2m_c[0])
    );

    for (genvar i = 0; i < GRID; i++) begin : g_cell
        ssc_cell #(
            .GRID(GRID), .COORD_BITS(COORD_BITS), .EW(EW), .DW(DW), .CW(CW), .IDX(i)
        ) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .mode(mode_reg), .cx(cx_reg),
            .valid_in(valid_c[i]), .px_in(px_c[i]),
            .sy_in(sy_c[i]), .dy2m_in(dy2m_c[i]), .cnt_in(cnt_c[i]),
            .valid_out(valid_c[i+1]), .px_out(px_c[i+1]),
            .sy_out(sy_c[i+1]), .dy2m_out(dy2m_c[i+1]), .cnt_out(cnt_c[i+1])
        );
    end

    assign m_valid           = valid_c[GRID];
    assign m_covered_count   = 5'(cnt_c[GRID]);
    assign m_shade_red_green = RG_TAB[cnt_c[GRID]];
    assign m_shade_blue      = BLUE_TAB[cnt_c[GRID]];
endmodule
`default_nettype wire
